### rtl/assert_macros.svh
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/lru_alloc_pkg.sv
// Package with constants and types of the LRU register allocator.
package lru_alloc_pkg;
  localparam int MaxVars = 256;
  localparam int NumRegs = 17;
  localparam int SlotBytes = 4;
  localparam int VarW = $clog2(MaxVars);
  localparam int RegW = 5;
  localparam int OffW = 16;
  localparam int AgeW = 16;

  localparam logic [2:0] CMD_ACCESS = 3'd0;
  localparam logic [2:0] CMD_STORE_ALL = 3'd1;
  localparam logic [2:0] CMD_STORE_REL = 3'd2;
  localparam logic [2:0] CMD_NEW_FUNC = 3'd3;
  localparam logic [2:0] CMD_RESERVE = 3'd4;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_GRANT = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [RegW-1:0] reg_index;
    logic [OffW-1:0] mem_offset;
    logic last;
  } result_t;
endpackage

### rtl/lru_alloc_ram.sv
// Generic single-port-write, one-read-port RAM with registered read.
module lru_alloc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/lru_alloc_out.sv
// Two-entry output queue that decouples result beats from the sequencer.
module lru_alloc_out import lru_alloc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  result_t push_data,
  output logic has_room,
  output logic empty,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output result_t head
);
  result_t q0, q1;
  logic [1:0] cnt;
  logic pop;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = cnt != 2'd0;
  assign has_room = cnt != 2'd2;
  assign empty = cnt == 2'd0;
  assign head = q0;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      q0 <= q1;
      if (push && cnt == 2'd1) q0 <= push_data;
      if (push && cnt == 2'd2) q1 <= push_data;
    end else if (push) begin
      if (cnt == 2'd0) q0 <= push_data;
      else q1 <= push_data;
    end
  end
endmodule

### rtl/lru_register_allocator_spill_unit.sv
// Top level of the LRU register allocator with spill.
// Maps variable ids onto 17 registers and emits store, load, grant and done
// beats. One command is handled at a time. Per-variable offset and register
// live in two synchronous RAMs (256 entries, clocked read); the known bit
// per variable is a flip-flop vector cleared at once by reset and by "new
// function", so no clearing pass is needed. Register state (busy, owner,
// age) is a 17-entry register file. Steps: a hit goes through accept, table
// read, check and grant. A miss goes through accept, table read, check, a
// scan over the 17 registers that ages busy registers and finds the first
// free one or the oldest, pick, load step and grant, with a store step
// before the load step when a register is spilled. Store all and store and
// release walk the registers and emit a store for each busy one, then done;
// new function, reserve and undefined codes go straight to done. A full
// output queue stalls every step that emits a beat. The register scan sets the rate.
// s_axis_tdata: cmd[2:0], var_id[10:3], reserve_bytes[26:11], zero fill.
// m_axis_tdata: reg_index[4:0], mem_offset[20:5], zero fill; tuser = kind.
`include "assert_macros.svh"
module lru_register_allocator_spill_unit import lru_alloc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // cmd, var_id, reserve_bytes
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [23:0] m_axis_tdata,   // reg_index, mem_offset
  output logic [1:0] m_axis_tuser,    // kind
  output logic m_axis_tlast
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD = 4'd1;
  localparam logic [3:0] ST_CHK = 4'd2;
  localparam logic [3:0] ST_SCAN = 4'd3;
  localparam logic [3:0] ST_VICT = 4'd4;
  localparam logic [3:0] ST_SPILL = 4'd5;
  localparam logic [3:0] ST_LOAD = 4'd6;
  localparam logic [3:0] ST_GRANT = 4'd7;
  localparam logic [3:0] ST_FLUSH = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;
  localparam logic [3:0] ST_FRD = 4'd10;
  localparam logic [3:0] ST_FEMIT = 4'd11;

  logic [3:0] state;
  logic [15:0] frame_base, frame_ptr;
  logic [2:0] cmd;
  logic [VarW-1:0] vid;
  logic [MaxVars-1:0] known;
  logic busy [NumRegs];
  logic [VarW-1:0] owner [NumRegs];
  logic [AgeW-1:0] age [NumRegs];
  logic [RegW-1:0] ridx, pick, victim;
  logic have_free, fresh;
  logic [AgeW-1:0] best;
  logic [OffW-1:0] my_off;

  // variable RAMs
  logic off_we, reg_we;
  logic [VarW-1:0] raddr;
  logic [OffW-1:0] off_wdata, off_rdata;
  logic [RegW-1:0] reg_rdata;

  lru_alloc_ram #(.Width(OffW), .Depth(MaxVars)) u_off (
    .clk, .we(off_we), .waddr(vid), .wdata(off_wdata), .raddr(raddr),
    .rdata(off_rdata));
  lru_alloc_ram #(.Width(RegW), .Depth(MaxVars)) u_reg (
    .clk, .we(reg_we), .waddr(vid), .wdata(pick), .raddr(raddr),
    .rdata(reg_rdata));

  // output queue
  logic push, has_room, q_empty;
  result_t push_data, head;
  lru_alloc_out u_out (
    .clk, .rst, .push, .push_data, .has_room, .empty(q_empty),
    .m_axis_tvalid, .m_axis_tready, .head);
  assign m_axis_tdata = {3'd0, head.mem_offset, head.reg_index};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  assign s_axis_tready = state == ST_IDLE;

  logic [16:0] slot_sum, res_sum;
  assign slot_sum = {1'b0, frame_ptr} + 17'(SlotBytes);
  assign res_sum = {1'b0, frame_ptr} + {1'b0, s_axis_tdata[26:11]};

  logic hit;
  assign hit = (reg_rdata < RegW'(NumRegs)) && busy[reg_rdata[RegW-1:0]] &&
               owner[reg_rdata] == vid;

  always_comb begin
    push = 1'b0;
    push_data = '0;
    off_we = 1'b0;
    off_wdata = slot_sum[16] ? 16'hFFFF : slot_sum[15:0];
    reg_we = 1'b0;
    raddr = vid;
    unique case (state)
      ST_IDLE: raddr = s_axis_tdata[10:3];
      ST_CHK: begin
        off_we = !known[vid];
        reg_we = 1'b0;
      end
      ST_FRD: raddr = owner[ridx];
      ST_VICT: raddr = owner[victim];
      ST_SPILL: begin
        // hold the victim's offset on the read port while the queue is full
        raddr = owner[victim];
        if (has_room) begin
          push = 1'b1;
          push_data = '{KIND_STORE, victim, off_rdata, 1'b0};
        end
      end
      ST_LOAD: if (has_room) begin
        push = !fresh;
        reg_we = 1'b1;
        push_data = '{KIND_LOAD, pick, my_off, 1'b0};
      end
      ST_GRANT: if (has_room) begin
        push = 1'b1;
        push_data = '{KIND_GRANT, pick, my_off, 1'b1};
      end
      ST_FEMIT: begin
        raddr = owner[ridx];
        if (has_room) begin
          push = 1'b1;
          push_data = '{KIND_STORE, ridx, off_rdata, 1'b0};
        end
      end
      ST_DONE: if (has_room) begin
        push = 1'b1;
        push_data = '{KIND_DONE, 5'd0, 16'd0, 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      frame_base <= 16'd8;
      frame_ptr <= 16'd0;
      known <= '0;
      for (int i = 0; i < NumRegs; i++) begin
        busy[i] <= 1'b0;
        age[i] <= '0;
      end
    end else begin
      if (cfg_we) frame_base <= cfg_wdata;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          cmd <= s_axis_tdata[2:0];
          vid <= s_axis_tdata[10:3];
          ridx <= '0;
          unique case (s_axis_tdata[2:0])
            CMD_ACCESS: state <= ST_RD;
            CMD_STORE_ALL, CMD_STORE_REL: state <= ST_FLUSH;
            CMD_NEW_FUNC: begin
              known <= '0;
              for (int i = 0; i < NumRegs; i++) begin
                busy[i] <= 1'b0;
                age[i] <= '0;
              end
              frame_ptr <= frame_base;
              state <= ST_DONE;
            end
            CMD_RESERVE: begin
              frame_ptr <= res_sum[16] ? 16'hFFFF : res_sum[15:0];
              state <= ST_DONE;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_RD: state <= ST_CHK;
        ST_CHK: begin
          fresh <= !known[vid];
          if (!known[vid]) begin
            known[vid] <= 1'b1;
            frame_ptr <= off_wdata;
            my_off <= off_wdata;
          end else begin
            my_off <= off_rdata;
          end
          if (known[vid] && hit) begin
            pick <= reg_rdata;
            state <= ST_GRANT;
          end else begin
            ridx <= '0;
            have_free <= 1'b0;
            best <= '0;
            victim <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // age busy registers, find first free and oldest
          if (busy[ridx]) begin
            if (age[ridx] != '1) age[ridx] <= age[ridx] + 1'b1;
            if (!have_free && (age[ridx] == '1 ? age[ridx] : age[ridx] + 1'b1) > best) begin
              best <= (age[ridx] == '1) ? age[ridx] : age[ridx] + 1'b1;
              victim <= ridx;
            end
          end else if (!have_free) begin
            have_free <= 1'b1;
            pick <= ridx;
          end
          if (ridx == RegW'(NumRegs - 1)) state <= ST_VICT;
          else ridx <= ridx + 1'b1;
        end
        ST_VICT: if (have_free) state <= ST_LOAD;
          else begin
            pick <= victim;
            state <= ST_SPILL;
          end
        ST_SPILL: if (has_room) state <= ST_LOAD;
        ST_LOAD: if (has_room) begin
          busy[pick] <= 1'b1;
          owner[pick] <= vid;
          state <= ST_GRANT;
        end
        ST_GRANT: if (has_room) begin
          age[pick] <= '0;
          state <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (busy[ridx]) state <= ST_FRD;
          else if (ridx == RegW'(NumRegs - 1)) state <= ST_DONE;
          else ridx <= ridx + 1'b1;
        end
        ST_FRD: state <= ST_FEMIT;
        ST_FEMIT: if (has_room) begin
          if (ridx == RegW'(NumRegs - 1)) state <= ST_DONE;
          else begin
            ridx <= ridx + 1'b1;
            state <= ST_FLUSH;
          end
        end
        ST_DONE: if (has_room) begin
          if (cmd == CMD_STORE_REL) begin
            for (int i = 0; i < NumRegs; i++) begin
              busy[i] <= 1'b0;
              age[i] <= '0;
            end
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_ready_idle, clk, rst, s_axis_tready, state == ST_IDLE, "ready outside idle")
  `ASSERT_IMP(a_push_room, clk, rst, push, has_room, "push into full queue")
  `ASSERT_IMP(a_empty_quiet, clk, rst, q_empty, !m_axis_tvalid, "valid with empty queue")
  `ASSERT_NEXT(a_grant_busy, clk, rst, state == ST_GRANT && has_room, busy[pick], "grant of free register")
endmodule
